// ===== rtl/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Level crossing sequencer package
// Types, register indexes, track phases and timer helpers shared by the
// crossing sequencer.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int TRACKS      = 4;
  localparam int TIMER_WIDTH = 24;
  localparam int CFG_WIDTH   = 24;
  localparam int TICK_WIDTH  = 8;
  localparam int OCC_WIDTH   = 4;
  localparam int CMP_WIDTH   = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
  localparam int CFG_IDX_WIDTH = 3;

  typedef logic [TIMER_WIDTH-1:0] timer_t;
  typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
  typedef logic [TICK_WIDTH-1:0]  tick_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CLOSING = 2'd1,
    PH_SECURED = 2'd2,
    PH_OPENING = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_TRACK_COUNT     = 3'd0,
    REG_BARRIERS_FITTED = 3'd1,
    REG_TRAIN_DELAY     = 3'd2,
    REG_STUCK_TIMEOUT   = 3'd3,
    REG_BARRIER_DELAY   = 3'd4,
    REG_BARRIER_TRAVEL  = 3'd5,
    REG_BELL            = 3'd6
  } cfg_reg_t;

  localparam logic [2:0] RST_TRACK_COUNT     = 3'd1;
  localparam logic       RST_BARRIERS_FITTED = 1'b0;
  localparam cfg_word_t  RST_TRAIN_DELAY     = CFG_WIDTH'(1000);
  localparam cfg_word_t  RST_STUCK_TIMEOUT   = CFG_WIDTH'(60000);
  localparam cfg_word_t  RST_BARRIER_DELAY   = CFG_WIDTH'(500);
  localparam cfg_word_t  RST_BARRIER_TRAVEL  = CFG_WIDTH'(800);
  localparam cfg_word_t  RST_BELL            = CFG_WIDTH'(2000);

  typedef struct packed {
    logic [OCC_WIDTH-1:0] outer_a_occupied;
    logic [OCC_WIDTH-1:0] inner_occupied;
    logic [OCC_WIDTH-1:0] outer_b_occupied;
    tick_t                elapsed_ticks;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           track_phases;
    logic                 crossing_shut;
    logic                 bell_on;
    cfg_word_t            barrier_position;
    logic [OCC_WIDTH-1:0] secured_mask;
  } out_item_t;

  typedef struct packed {
    phase_t phase;
    timer_t phase_timer;
    timer_t clear_timer;
    logic   clear_running;
    logic   inner_seen;
    logic   last_a;
    logic   last_b;
  } track_state_t;

  localparam track_state_t TRACK_RESET = '{
    phase:         PH_IDLE,
    phase_timer:   '0,
    clear_timer:   '0,
    clear_running: 1'b0,
    inner_seen:    1'b0,
    last_a:        1'b0,
    last_b:        1'b0
  };

  function automatic timer_t sat_add(timer_t a, tick_t e);
    logic [TIMER_WIDTH:0] sum;
    sum = {1'b0, a} + (TIMER_WIDTH+1)'(e);
    return sum[TIMER_WIDTH] ? '1 : sum[TIMER_WIDTH-1:0];
  endfunction

  function automatic logic at_least(timer_t t, cfg_word_t c);
    return CMP_WIDTH'(t) >= CMP_WIDTH'(c);
  endfunction

endpackage

// ===== rtl/level_crossing_sequencer.sv =====
// ----------------------------------------------------------------------------
// Level crossing sequencer
// Path: input transaction to result via the input register, then the result
// register. Throughput: one transaction per cycle unless out_ready stalls the
// output; set by the combinational per-track update of phases, timers, boom position.
// Reset: synchronous, active low; all tracks idle, timers and boom at zero,
// registers at their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module level_crossing_sequencer
  import lcs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,

  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,

  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  cfg_word_t                cfg_data
);

  logic [2:0]   cfg_track_count_r;
  logic         cfg_barriers_fitted_r;
  cfg_word_t    cfg_train_delay_r;
  cfg_word_t    cfg_stuck_timeout_r;
  cfg_word_t    cfg_barrier_delay_r;
  cfg_word_t    cfg_barrier_travel_r;
  cfg_word_t    cfg_bell_r;

  logic         s1_valid_r;
  in_item_t     s1_data_r;
  logic         out_valid_r;
  out_item_t    out_data_r;

  track_state_t trk_r   [TRACKS];
  track_state_t trk_nxt [TRACKS];
  timer_t       active_timer_r;
  timer_t       active_timer_nxt;
  cfg_word_t    boom_r;
  cfg_word_t    boom_nxt;
  out_item_t    out_nxt;

  logic         advance;
  logic         fire;

  assign advance   = !out_valid_r || out_ready;
  assign fire      = s1_valid_r && advance;
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_track_count_r     <= RST_TRACK_COUNT;
      cfg_barriers_fitted_r <= RST_BARRIERS_FITTED;
      cfg_train_delay_r     <= RST_TRAIN_DELAY;
      cfg_stuck_timeout_r   <= RST_STUCK_TIMEOUT;
      cfg_barrier_delay_r   <= RST_BARRIER_DELAY;
      cfg_barrier_travel_r  <= RST_BARRIER_TRAVEL;
      cfg_bell_r            <= RST_BELL;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TRACK_COUNT:     cfg_track_count_r     <= cfg_data[2:0];
        REG_BARRIERS_FITTED: cfg_barriers_fitted_r <= cfg_data[0];
        REG_TRAIN_DELAY:     cfg_train_delay_r     <= cfg_data;
        REG_STUCK_TIMEOUT:   cfg_stuck_timeout_r   <= cfg_data;
        REG_BARRIER_DELAY:   cfg_barrier_delay_r   <= cfg_data;
        REG_BARRIER_TRAVEL:  cfg_barrier_travel_r  <= cfg_data;
        REG_BELL:            cfg_bell_r            <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [TRACKS-1:0]   a_vec;
    logic [TRACKS-1:0]   i_vec;
    logic [TRACKS-1:0]   b_vec;
    logic [2*TRACKS-1:0] phase_vec;
    logic [TRACKS-1:0]   sec_vec;
    track_state_t        cur;
    track_state_t        nx;
    tick_t               e;
    logic                trk_active;
    logic                all_clear;
    logic                edge_seen;
    logic                was_shut;
    logic                shut;
    logic                closing;
    cfg_word_t           target;

    e         = s1_data_r.elapsed_ticks;
    a_vec     = TRACKS'(s1_data_r.outer_a_occupied);
    i_vec     = TRACKS'(s1_data_r.inner_occupied);
    b_vec     = TRACKS'(s1_data_r.outer_b_occupied);
    was_shut  = 1'b0;
    shut      = 1'b0;
    closing   = 1'b0;
    phase_vec = '0;
    sec_vec   = '0;

    for (int t = 0; t < TRACKS; t++) begin
      trk_active = (t == 0) || (int'(cfg_track_count_r) > t);
      cur = trk_active ? trk_r[t] : TRACK_RESET;
      nx  = cur;
      if (cur.phase != PH_IDLE) begin
        was_shut = 1'b1;
      end

      all_clear = !a_vec[t] && !i_vec[t] && !b_vec[t];
      if (all_clear) begin
        if (cur.clear_running) begin
          nx.clear_timer = sat_add(cur.clear_timer, e);
        end else begin
          nx.clear_running = 1'b1;
          nx.clear_timer   = '0;
        end
      end else begin
        nx.clear_running = 1'b0;
        nx.clear_timer   = '0;
      end
      nx.inner_seen = cur.inner_seen || i_vec[t];
      edge_seen = (a_vec[t] && !cur.last_a) || (b_vec[t] && !cur.last_b);
      nx.last_a = a_vec[t];
      nx.last_b = b_vec[t];
      nx.phase_timer = sat_add(cur.phase_timer, e);

      unique case (cur.phase)
        PH_IDLE: begin
          if (edge_seen || i_vec[t]) begin
            nx.phase       = PH_CLOSING;
            nx.phase_timer = '0;
          end
        end
        PH_CLOSING: begin
          if (at_least(nx.phase_timer, cfg_train_delay_r)) begin
            nx.phase       = PH_SECURED;
            nx.phase_timer = '0;
          end
        end
        PH_SECURED: begin
          if ((nx.inner_seen && !i_vec[t]) ||
              (!nx.inner_seen && nx.clear_running &&
               at_least(nx.clear_timer, cfg_stuck_timeout_r))) begin
            nx.phase       = PH_OPENING;
            nx.phase_timer = '0;
          end
        end
        PH_OPENING: begin
          if (at_least(nx.phase_timer, cfg_train_delay_r)) begin
            nx.inner_seen  = 1'b0;
            nx.phase       = PH_IDLE;
            nx.phase_timer = '0;
          end
        end
        default: ;
      endcase

      if (!trk_active) begin
        nx = TRACK_RESET;
      end
      trk_nxt[t] = nx;

      if (nx.phase != PH_IDLE) begin
        shut = 1'b1;
      end
      if (nx.phase == PH_CLOSING || nx.phase == PH_SECURED) begin
        closing = 1'b1;
      end
      phase_vec[2*t +: 2] = nx.phase;
      sec_vec[t]          = (nx.phase == PH_SECURED);
    end

    active_timer_nxt = sat_add(active_timer_r, e);
    if (!was_shut && shut) begin
      active_timer_nxt = '0;
    end

    target = (closing && at_least(active_timer_nxt, cfg_barrier_delay_r)) ?
             cfg_barrier_travel_r : '0;
    boom_nxt = boom_r;
    if (!cfg_barriers_fitted_r) begin
      boom_nxt = '0;
    end else if (boom_r < target) begin
      boom_nxt = ((target - boom_r) > CFG_WIDTH'(e)) ? boom_r + CFG_WIDTH'(e) : target;
    end else if (boom_r > target) begin
      boom_nxt = ((boom_r - target) > CFG_WIDTH'(e)) ? boom_r - CFG_WIDTH'(e) : target;
    end

    out_nxt.track_phases     = 8'(phase_vec);
    out_nxt.crossing_shut    = shut;
    out_nxt.bell_on          = shut && !at_least(active_timer_nxt, cfg_bell_r);
    out_nxt.barrier_position = boom_nxt;
    out_nxt.secured_mask     = OCC_WIDTH'(sec_vec);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < TRACKS; t++) begin
        trk_r[t] <= TRACK_RESET;
      end
      active_timer_r <= '0;
      boom_r         <= '0;
    end else if (fire) begin
      for (int t = 0; t < TRACKS; t++) begin
        trk_r[t] <= trk_nxt[t];
      end
      active_timer_r <= active_timer_nxt;
      boom_r         <= boom_nxt;
    end
  end

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side accepts");

  a_shut_matches_phases: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.crossing_shut == (out_data_r.track_phases != 8'd0)))
    else $error("crossing_shut disagrees with track phases");

  a_bell_only_shut: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.bell_on |-> out_data_r.crossing_shut)
    else $error("bell on while crossing open");

  a_no_boom_when_unfitted: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !cfg_barriers_fitted_r |=> out_data_r.barrier_position == '0)
    else $error("boom moved without barriers fitted");

endmodule
